// ===== hdl/multi_channel_timed_debouncer_top_assert.svh =====
// Assertion macros used by the debouncer queue RTL.
`ifndef MULTI_CHANNEL_TIMED_DEBOUNCER_TOP_ASSERT_SVH
`define MULTI_CHANNEL_TIMED_DEBOUNCER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCTD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("debouncer assertion failed");

// Next-cycle implication, checked outside reset.
`define MCTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("debouncer assertion failed");

`endif

// ===== hdl/mctd_pkg.sv =====
package mctd_pkg;

  localparam int CHANNELS = 32;
  localparam int CH_W     = 5;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TICK_W   = 32;
  localparam int DBT_W    = 16;
  localparam int CNT_W    = 32;
  localparam int MASK_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INJECT_VALID = 2'd0,
    REG_INJECT_LEVEL = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_RISE = 2'd1,
    EDGE_FALL = 2'd2
  } edge_kind_t;

  // One classified scan, queued between front and back.
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic              in_range;
    logic              en;
    logic              raw;
    logic [TICK_W-1:0] now;
    logic [DBT_W-1:0]  dbt;
  } job_t;

  // Channel state record.
  typedef struct packed {
    logic              last_raw;
    logic              settled;
    logic              pending;
    logic [TICK_W-1:0] change_stamp;
    logic [CNT_W-1:0]  edge_counter;
  } chan_state_t;

endpackage

// ===== hdl/mctd_front.sv =====
module mctd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mctd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mctd_pkg::MASK_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mctd_pkg::CH_W-1:0]     channel,
  input  logic                          pin_level,
  input  logic [mctd_pkg::TICK_W-1:0]   now_tick,
  input  logic [mctd_pkg::DBT_W-1:0]    debounce_ticks,
  input  logic                          pin_polarity,
  input  logic                          sensor_enabled,
  output logic                          push_valid,
  input  logic                          push_ready,
  output mctd_pkg::job_t                push_item
);
  import mctd_pkg::*;

  logic [MASK_W-1:0] inject_valid_mask;
  logic [MASK_W-1:0] inject_level_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      inject_valid_mask <= '0;
      inject_level_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INJECT_VALID: inject_valid_mask <= cfg_data;
        REG_INJECT_LEVEL: inject_level_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Injected level bypasses polarity.
  always_comb begin
    push_item.ch       = channel;
    push_item.in_range = ({27'd0, channel} < CHANNELS);
    push_item.en       = sensor_enabled;
    push_item.raw      = inject_valid_mask[channel] ? inject_level_mask[channel]
                                                    : (pin_level ^ ~pin_polarity);
    push_item.now      = now_tick;
    push_item.dbt      = debounce_ticks;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ===== hdl/mctd_queue.sv =====
`include "multi_channel_timed_debouncer_top_assert.svh"

module mctd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mctd_pkg::job_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mctd_pkg::job_t pop_item
);
  import mctd_pkg::*;

  job_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  logic               pop;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `MCTD_ASSERT_NOW(a_count_bound, 1'b1, count <= Q_CNT_W'(Q_DEPTH))
  `MCTD_ASSERT_NEXT(a_count_up, push && !pop && !rst, count == $past(count) + 1'b1)
  `MCTD_ASSERT_NEXT(a_count_down, pop && !push && !rst, count == $past(count) - 1'b1)

endmodule

// ===== hdl/mctd_back.sv =====
module mctd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  mctd_pkg::job_t              pop_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mctd_pkg::CH_W-1:0]   out_channel,
  output logic                        stable_level,
  output logic [1:0]                  edge_kind,
  output logic [mctd_pkg::CNT_W-1:0]  edge_total,
  output logic [mctd_pkg::TICK_W-1:0] edge_time
);
  import mctd_pkg::*;

  chan_state_t          chans [CHANNELS];
  chan_state_t          cur;
  chan_state_t          upd;
  logic [CH_IDX_W-1:0]  idx;
  logic                 take;
  logic                 changed;
  logic [TICK_W-1:0]    age;
  logic                 fire;
  logic                 is_edge;
  edge_kind_t           kind;

  assign pop_ready = !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;
  assign idx       = CH_IDX_W'(pop_item.ch);
  assign cur       = chans[idx];

  always_comb begin
    upd     = cur;
    changed = pop_item.raw != cur.last_raw;
    if (changed) begin
      upd.last_raw     = pop_item.raw;
      upd.change_stamp = pop_item.now;
      upd.pending      = 1'b1;
    end
    age     = pop_item.now - upd.change_stamp;
    fire    = upd.pending && (age >= TICK_W'(pop_item.dbt));
    is_edge = fire && (pop_item.raw != cur.settled);
    kind    = EDGE_NONE;
    if (fire) begin
      upd.pending = 1'b0;
    end
    if (is_edge) begin
      upd.settled      = pop_item.raw;
      upd.edge_counter = cur.edge_counter + 1'b1;
      kind             = pop_item.raw ? EDGE_RISE : EDGE_FALL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chans[i] <= '0;
      end
    end else if (take && pop_item.in_range && pop_item.en) begin
      chans[idx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_channel <= pop_item.ch;
      if (!pop_item.in_range) begin
        stable_level <= 1'b0;
        edge_kind    <= EDGE_NONE;
        edge_total   <= '0;
        edge_time    <= '0;
      end else if (!pop_item.en) begin
        stable_level <= cur.settled;
        edge_kind    <= EDGE_NONE;
        edge_total   <= cur.edge_counter;
        edge_time    <= '0;
      end else begin
        stable_level <= upd.settled;
        edge_kind    <= kind;
        edge_total   <= upd.edge_counter;
        edge_time    <= is_edge ? pop_item.now : '0;
      end
    end
  end

endmodule

// ===== hdl/multi_channel_timed_debouncer_top.sv =====
// Channel   Handshake               Payload
// --------  ----------------------  ---------------------------------------------
// scan in   in_valid / in_ready     channel, pin_level, now_tick, debounce_ticks,
//                                   pin_polarity, sensor_enabled
// result    out_valid / out_ready   out_channel, stable_level, edge_kind,
//                                   edge_total, edge_time
// config    cfg_we (no handshake)   cfg_index, cfg_data
//
// One scan per cycle sustained while out_ready holds; out_valid rises at the edge that
// pops the scan from the queue slot it was written to on acceptance, and the result
// transaction completes at a later edge, when out_ready is high.
// The rate is set by the single read-modify-write of channel state per cycle.
// Reset (rst, synchronous) clears all channel state, the masks and the queue at once.
// A stalled result port fills the two-entry queue; in_ready drops only when it is full.
module multi_channel_timed_debouncer_top (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [mctd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mctd_pkg::MASK_W-1:0]   cfg_data,
  // scan transactions
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mctd_pkg::CH_W-1:0]     channel,
  input  logic                          pin_level,
  input  logic [mctd_pkg::TICK_W-1:0]   now_tick,
  input  logic [mctd_pkg::DBT_W-1:0]    debounce_ticks,
  input  logic                          pin_polarity,
  input  logic                          sensor_enabled,
  // result transactions
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mctd_pkg::CH_W-1:0]     out_channel,
  output logic                          stable_level,
  output logic [1:0]                    edge_kind,
  output logic [mctd_pkg::CNT_W-1:0]    edge_total,
  output logic [mctd_pkg::TICK_W-1:0]   edge_time
);
  import mctd_pkg::*;

  // front -> queue
  logic push_valid;
  logic push_ready;
  job_t push_item;

  // queue -> back
  logic pop_valid;
  logic pop_ready;
  job_t pop_item;

  // Front: holds the inject masks, resolves the raw level (injected or
  // polarity-corrected pin) and flags out-of-range channels.
  mctd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .channel        (channel),
    .pin_level      (pin_level),
    .now_tick       (now_tick),
    .debounce_ticks (debounce_ticks),
    .pin_polarity   (pin_polarity),
    .sensor_enabled (sensor_enabled),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  // Short queue decouples scan intake from result backpressure.
  mctd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: per-channel state update (stamp, wrapping age compare, edge count)
  // and the registered result stage.
  mctd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_channel  (out_channel),
    .stable_level (stable_level),
    .edge_kind    (edge_kind),
    .edge_total   (edge_total),
    .edge_time    (edge_time)
  );

endmodule

// ===== tb/tb_multi_channel_timed_debouncer_top.sv =====
`timescale 1ns / 1ps

module tb_multi_channel_timed_debouncer_top;
  import mctd_pkg::*;

  // Scan transaction as seen on the input port
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic              pin;
    logic              ahi;
    logic              en;
    logic [DBT_W-1:0]  dbt;
    logic [TICK_W-1:0] now;
  } scan_t;

  // Result transaction as seen on the output port
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic              stable;
    edge_kind_t        kind;
    logic [CNT_W-1:0]  total;
    logic [TICK_W-1:0] etime;
  } result_t;

  typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_t;

  // One line of the directed table: either a scan or a register write
  typedef struct {
    row_kind_t         kind;
    scan_t             s;
    bit                typed;
    result_t           exp;
    reg_idx_t          idx;
    logic [MASK_W-1:0] data;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MASK_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [CH_W-1:0]      channel;
  logic                 pin_level;
  logic [TICK_W-1:0]    now_tick;
  logic [DBT_W-1:0]     debounce_ticks;
  logic                 pin_polarity;
  logic                 sensor_enabled;
  logic                 out_valid;
  logic                 out_ready;
  logic [CH_W-1:0]      out_channel;
  logic                 stable_level;
  logic [1:0]           edge_kind;
  logic [CNT_W-1:0]     edge_total;
  logic [TICK_W-1:0]    edge_time;

  multi_channel_timed_debouncer_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .channel        (channel),
    .pin_level      (pin_level),
    .now_tick       (now_tick),
    .debounce_ticks (debounce_ticks),
    .pin_polarity   (pin_polarity),
    .sensor_enabled (sensor_enabled),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .stable_level   (stable_level),
    .edge_kind      (edge_kind),
    .edge_total     (edge_total),
    .edge_time      (edge_time)
  );

  // Shadow of the block: masks and per-channel debounce state
  logic [MASK_W-1:0] inj_valid;
  logic [MASK_W-1:0] inj_level;
  logic              ch_last    [CHANNELS];
  logic              ch_settled [CHANNELS];
  logic              ch_pending [CHANNELS];
  logic [TICK_W-1:0] ch_stamp   [CHANNELS];
  logic [CNT_W-1:0]  ch_edges   [CHANNELS];

  result_t due_results[$];   // results owed by the block, oldest first
  row_t    scan_table[$];    // directed stimulus
  int      fail_count = 0;

  // Typed-in expectation riding along with the scan currently offered
  bit      scan_has_ref;
  result_t scan_ref;

  // Idle rates in percent, and the long receiver hold-off request
  int send_idle_pct = 11;
  int recv_idle_pct = 84;
  bit hold_req      = 1'b0;
  int hold_left     = 0;

  // Random stimulus state: a running tick and a per-channel "true" input
  logic [TICK_W-1:0] tick;
  logic              true_lvl [CHANNELS];
  logic              ch_pol   [CHANNELS];
  logic [DBT_W-1:0]  ch_dbt   [CHANNELS];

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake hangs
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

  // Next state of one channel for an accepted scan, and the result it owes.
  // Disabled scans leave the state alone but still report it.
  function automatic result_t debounce_scan(scan_t s);
    result_t           r;
    logic              lvl;
    logic [TICK_W-1:0] elapsed;
    r.ch     = s.ch;
    r.stable = 1'b0;
    r.kind   = EDGE_NONE;
    r.total  = '0;
    r.etime  = '0;
    if (s.ch >= CHANNELS)
      return r;
    if (s.en) begin
      // injected level bypasses polarity
      if (inj_valid[s.ch])
        lvl = inj_level[s.ch];
      else
        lvl = s.ahi ? s.pin : ~s.pin;
      if (lvl != ch_last[s.ch]) begin
        ch_last[s.ch]    = lvl;
        ch_stamp[s.ch]   = s.now;
        ch_pending[s.ch] = 1'b1;
      end
      elapsed = s.now - ch_stamp[s.ch];   // wraps mod 2^32
      if (ch_pending[s.ch] && elapsed >= {16'h0, s.dbt}) begin
        ch_pending[s.ch] = 1'b0;
        if (lvl != ch_settled[s.ch]) begin
          r.kind           = (lvl > ch_settled[s.ch]) ? EDGE_RISE : EDGE_FALL;
          ch_settled[s.ch] = lvl;
          ch_edges[s.ch]   = ch_edges[s.ch] + 1'b1;
          r.etime          = s.now;
        end
      end
    end
    r.stable = ch_settled[s.ch];
    r.total  = ch_edges[s.ch];
    return r;
  endfunction

  // Sample both ports at the rising edge. Results are checked before the
  // new scan is predicted; a result never belongs to a scan of the same edge.
  always @(posedge clk) begin
    result_t exp_r;
    result_t pred;
    scan_t   s;
    if (rst) begin
      inj_valid = '0;
      inj_level = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        ch_last[c]    = 1'b0;
        ch_settled[c] = 1'b0;
        ch_pending[c] = 1'b0;
        ch_stamp[c]   = '0;
        ch_edges[c]   = '0;
      end
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_INJECT_VALID: inj_valid = cfg_data;
          REG_INJECT_LEVEL: inj_level = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result transaction with nothing expected (channel %0d)", out_channel);
          fail_count++;
        end else begin
          exp_r = due_results.pop_front();
          if (out_channel !== exp_r.ch) begin
            $error("out_channel mismatch: expected %0d, got %0d", exp_r.ch, out_channel);
            fail_count++;
          end
          if (stable_level !== exp_r.stable) begin
            $error("stable_level mismatch: expected %0d, got %0d", exp_r.stable,
                   stable_level);
            fail_count++;
          end
          if (edge_kind !== exp_r.kind) begin
            $error("edge_kind mismatch: expected %0d, got %0d", exp_r.kind, edge_kind);
            fail_count++;
          end
          if (edge_total !== exp_r.total) begin
            $error("edge_total mismatch: expected %0d, got %0d", exp_r.total, edge_total);
            fail_count++;
          end
          if (edge_time !== exp_r.etime) begin
            $error("edge_time mismatch: expected %0h, got %0h", exp_r.etime, edge_time);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        s.ch  = channel;
        s.pin = pin_level;
        s.ahi = pin_polarity;
        s.en  = sensor_enabled;
        s.dbt = debounce_ticks;
        s.now = now_tick;
        pred  = debounce_scan(s);
        // typed-in rows are checked against the literal value
        due_results.push_back(scan_has_ref ? scan_ref : pred);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // two-entry queue fills and in_ready has to drop.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 120;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one scan transaction; called and returns at a falling edge.
  // valid stays high into the next call, so back-to-back scans never toggle it.
  task automatic send_scan(scan_t s, bit typed, result_t exp_r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    channel        <= s.ch;
    pin_level      <= s.pin;
    pin_polarity   <= s.ahi;
    sensor_enabled <= s.en;
    debounce_ticks <= s.dbt;
    now_tick       <= s.now;
    scan_has_ref   <= typed;
    scan_ref       <= exp_r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [MASK_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every owed result is back or the spin limit runs out, then add pipeline margin
  task automatic wait_idle();
    int spin;
    spin = 0;
    while (due_results.size() != 0 && spin < 5000) begin
      @(negedge clk);
      spin++;
    end
    repeat (4) @(negedge clk);
  endtask

  function automatic void add_scan(logic [CH_W-1:0] ch, logic pin, logic ahi, logic en,
                                   logic [DBT_W-1:0] dbt, logic [TICK_W-1:0] now,
                                   bit typed = 1'b0, logic stable = 1'b0,
                                   edge_kind_t kind = EDGE_NONE,
                                   logic [CNT_W-1:0] total = '0,
                                   logic [TICK_W-1:0] etime = '0);
    row_t r;
    r.kind     = ROW_SCAN;
    r.s.ch     = ch;
    r.s.pin    = pin;
    r.s.ahi    = ahi;
    r.s.en     = en;
    r.s.dbt    = dbt;
    r.s.now    = now;
    r.typed    = typed;
    r.exp.ch   = ch;
    r.exp.stable = stable;
    r.exp.kind = kind;
    r.exp.total = total;
    r.exp.etime = etime;
    r.idx      = REG_INJECT_VALID;
    r.data     = '0;
    scan_table.push_back(r);
  endfunction

  function automatic void add_cfg(reg_idx_t idx, logic [MASK_W-1:0] val);
    row_t r;
    r.kind  = ROW_CFG;
    r.s     = '0;
    r.typed = 1'b0;
    r.exp   = '0;
    r.idx   = idx;
    r.data  = val;
    scan_table.push_back(r);
  endfunction

  // One random scan. Mostly a handful of busy channels with slowly moving
  // levels plus bounce, so debounce windows actually expire; the rest is noise.
  function automatic scan_t random_scan();
    scan_t s;
    int    r;
    s.ch = ($urandom_range(99) < 60) ? CH_W'($urandom_range(7))
                                     : CH_W'($urandom_range(CHANNELS - 1));
    r = $urandom_range(99);
    if (r < 70)      tick = tick + $urandom_range(8);
    else if (r < 90) tick = tick + $urandom_range(200, 9);
    else if (r < 97) tick = tick + $urandom_range(65535);
    else             tick = $urandom;   // jumps, wrap included
    s.now = tick;
    if ($urandom_range(99) < 8)
      true_lvl[s.ch] = ~true_lvl[s.ch];
    s.pin = ($urandom_range(99) < 15) ? ~true_lvl[s.ch] : true_lvl[s.ch];
    s.ahi = ($urandom_range(99) < 5) ? ~ch_pol[s.ch] : ch_pol[s.ch];
    s.en  = ($urandom_range(99) < 92);
    r = $urandom_range(99);
    if (r < 80)      s.dbt = ch_dbt[s.ch];
    else if (r < 92) s.dbt = DBT_W'($urandom_range(65535));
    else if (r < 97) s.dbt = '0;
    else             s.dbt = '1;
    return s;
  endfunction

  initial begin
    result_t no_ref;
    no_ref = '0;

    // every input known from time zero
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_INJECT_VALID;
    cfg_data       = '0;
    in_valid       = 1'b0;
    channel        = '0;
    pin_level      = 1'b0;
    now_tick       = '0;
    debounce_ticks = '0;
    pin_polarity   = 1'b1;
    sensor_enabled = 1'b0;
    scan_has_ref   = 1'b0;
    scan_ref       = '0;
    tick           = $urandom;
    for (int c = 0; c < CHANNELS; c++) begin
      true_lvl[c] = $urandom_range(1);
      ch_pol[c]   = $urandom_range(1);
      ch_dbt[c]   = DBT_W'($urandom_range(30));
    end

    // Directed table. Rows with typed values come straight from the spec.
    //        ch  pin ahi en  dbt       now
    // no change after reset
    add_scan(0,  0,  1,  1,  16'd0,    32'd0,        1, 0, EDGE_NONE, 0, 0);
    // zero debounce: accepted in the same scan
    add_scan(0,  1,  1,  1,  16'd0,    32'd100,      1, 1, EDGE_RISE, 1, 100);
    add_scan(0,  0,  1,  1,  16'd0,    32'hFFFFFFFF, 1, 0, EDGE_FALL, 2, 32'hFFFFFFFF);
    // longest debounce time, one tick short then exactly reached
    add_scan(1,  1,  1,  1,  16'hFFFF, 32'd1000,     1, 0, EDGE_NONE, 0, 0);
    add_scan(1,  1,  1,  1,  16'hFFFF, 32'd66534,    1, 0, EDGE_NONE, 0, 0);
    add_scan(1,  1,  1,  1,  16'hFFFF, 32'd66535,    1, 1, EDGE_RISE, 1, 66535);
    // elapsed time across the tick wrap
    add_scan(2,  1,  1,  1,  16'h20,   32'hFFFFFFF0, 1, 0, EDGE_NONE, 0, 0);
    add_scan(2,  1,  1,  1,  16'h20,   32'h10,       1, 1, EDGE_RISE, 1, 32'h10);
    // disabled channel reports state, changes nothing
    add_scan(2,  0,  1,  0,  16'd0,    32'h100,      1, 1, EDGE_NONE, 1, 0);
    // active-low pin
    add_scan(3,  0,  0,  1,  16'd0,    32'd5,        1, 1, EDGE_RISE, 1, 5);
    add_scan(3,  1,  0,  1,  16'd0,    32'd6,        1, 0, EDGE_FALL, 2, 6);
    // glitch: returns to settled level before the window ends, no edge
    add_scan(4,  1,  1,  1,  16'd10,   32'd50,       1, 0, EDGE_NONE, 0, 0);
    add_scan(4,  0,  1,  1,  16'd10,   32'd55,       1, 0, EDGE_NONE, 0, 0);
    add_scan(4,  0,  1,  1,  16'd10,   32'd70,       1, 0, EDGE_NONE, 0, 0);
    // top channel
    add_scan(31, 1,  1,  1,  16'd0,    32'h12345678, 1, 1, EDGE_RISE, 1, 32'h12345678);
    add_scan(31, 1,  1,  1,  16'd5,    32'h12345679, 1, 1, EDGE_NONE, 1, 0);
    // injection on every channel; injected level ignores pin and polarity
    add_cfg(REG_INJECT_VALID, 32'hFFFFFFFF);
    add_cfg(REG_INJECT_LEVEL, 32'h00000050);
    add_scan(5,  1,  1,  1,  16'd0,    32'd200,      1, 0, EDGE_NONE, 0, 0);
    add_scan(6,  0,  0,  1,  16'd0,    32'd201,      1, 1, EDGE_RISE, 1, 201);
    add_scan(4,  0,  1,  1,  16'd0,    32'd202,      1, 1, EDGE_RISE, 1, 202);
    add_cfg(REG_INJECT_VALID, 32'h0);
    add_cfg(REG_INJECT_LEVEL, 32'h0);
    add_scan(0,  1,  1,  1,  16'd3,    32'd300);
    add_scan(0,  1,  1,  1,  16'd3,    32'd303);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (scan_table[i]) begin
      if (scan_table[i].kind == ROW_CFG) begin
        in_valid <= 1'b0;
        wait_idle();
        write_reg(scan_table[i].idx, scan_table[i].data);
      end else begin
        send_scan(scan_table[i].s, scan_table[i].typed, scan_table[i].exp);
      end
    end

    // Random part: three idle profiles, each with its own mask setting
    for (int ph = 0; ph < 3; ph++) begin
      in_valid <= 1'b0;
      wait_idle();
      case (ph)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 84;
          write_reg(REG_INJECT_VALID, $urandom & $urandom);
          write_reg(REG_INJECT_LEVEL, $urandom);
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 11;
          write_reg(REG_INJECT_VALID, $urandom & $urandom);
          write_reg(REG_INJECT_LEVEL, 32'hFFFFFFFF);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_reg(REG_INJECT_VALID, 32'h0);
          write_reg(REG_INJECT_LEVEL, 32'h0);
        end
      endcase
      for (int n = 0; n < 250; n++) begin
        // long receiver stall while scans keep coming
        if (ph == 2 && n == 60)
          hold_req = 1'b1;
        send_scan(random_scan(), 1'b0, no_ref);
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    if (due_results.size() != 0) begin
      $error("%0d result transactions never arrived", due_results.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
